/* rtl/turbo_button_repeater_core_macros.svh */
// Assertion macros shared by the turbo button repeater RTL
`ifndef TURBO_BUTTON_REPEATER_CORE_MACROS_SVH
`define TURBO_BUTTON_REPEATER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TBR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define TBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define TBR_ASSERT_SAME(label, clk, rst, ante, cons)
`define TBR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/tbr_pkg.sv */
// Types and constants of the turbo button repeater
package tbr_pkg;

   localparam int unsigned BTN_W   = 64;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned DUR_W   = 26;
   localparam int unsigned CSR_A_W = 3;

   localparam logic [BTN_W-1:0]  STICK_PSEUDO_MASK = 64'h0000_0000_00FF_0000;
   localparam logic [TIME_W-1:0] GUARD_US          = 32'd10000;
   localparam logic [DUR_W-1:0]  PRESS_TIME_RESET  = 26'd50000;
   localparam logic [DUR_W-1:0]  RELEASE_TIME_RESET = 26'd50000;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_TURBO_MASK   = 3'd0,
      CSR_PRESS_TIME   = 3'd1,
      CSR_RELEASE_TIME = 3'd2,
      CSR_LEFT_MASK    = 3'd3,
      CSR_RIGHT_MASK   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'b001,
      ST_PRESSED  = 3'b010,
      ST_RELEASED = 3'b100
   } turbo_state_type;

endpackage

/* rtl/turbo_button_repeater_core.sv */
// Turbo button repeater: auto-fire of masked buttons with left and right views
// Output: a result is registered in the cycle after its accepted request beat.
// Throughput: one request beat per cycle while no held response blocks it; the
// phase update is a 32-bit subtract and compare, done in the accepting cycle.
// Reset: synchronous; control and CSR registers return to their reset values,
// turbo goes idle, and no response is held.
`include "turbo_button_repeater_core_macros.svh"

module turbo_button_repeater_core
   import tbr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [BTN_W-1:0]         req_raw_buttons,
   input  logic [TIME_W-1:0]        req_now_us,
   input  logic                     req_paused,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [BTN_W-1:0]         rsp_drive_full,
   output logic [BTN_W-1:0]         rsp_drive_left,
   output logic [BTN_W-1:0]         rsp_drive_right,
   output logic                     rsp_stopped,

   input  logic                     csr_wr_en,
   input  logic [CSR_A_W-1:0]       csr_index,
   input  logic [BTN_W-1:0]         csr_wdata
);

   logic [BTN_W-1:0]  turbo_mask_ff, turbo_mask_in;
   logic [DUR_W-1:0]  press_time_ff, press_time_in;
   logic [DUR_W-1:0]  release_time_ff, release_time_in;
   logic [BTN_W-1:0]  left_mask_ff, left_mask_in;
   logic [BTN_W-1:0]  right_mask_ff, right_mask_in;

   turbo_state_type   state_ff, state_in;
   logic [TIME_W-1:0] last_toggle_ff, last_toggle_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BTN_W-1:0]  drive_full_ff, drive_full_in;
   logic [BTN_W-1:0]  drive_left_ff, drive_left_in;
   logic [BTN_W-1:0]  drive_right_ff, drive_right_in;
   logic              stopped_ff, stopped_in;

   logic              req_accept;
   logic              csr_hit;
   logic [BTN_W-1:0]  clean_btn;
   logic [BTN_W-1:0]  turbo_btn;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] limit;
   logic              result_valid;
   logic              result_stop;
   logic [BTN_W-1:0]  result_word;
   turbo_state_type   step_state;
   logic [TIME_W-1:0] step_toggle;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign clean_btn = req_raw_buttons & ~STICK_PSEUDO_MASK;
   assign turbo_btn = clean_btn & turbo_mask_ff;
   assign elapsed   = req_now_us - last_toggle_ff;
   assign limit     = (state_ff == ST_PRESSED) ? {{(TIME_W-DUR_W){1'b0}}, press_time_ff}
                                                : {{(TIME_W-DUR_W){1'b0}}, release_time_ff};

   // register writes
   always_comb begin
      turbo_mask_in   = turbo_mask_ff;
      press_time_in   = press_time_ff;
      release_time_in = release_time_ff;
      left_mask_in    = left_mask_ff;
      right_mask_in   = right_mask_ff;
      csr_hit         = 1'b0;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TURBO_MASK: begin
               turbo_mask_in = csr_wdata;
               csr_hit       = 1'b1;
            end
            CSR_PRESS_TIME: begin
               press_time_in = csr_wdata[DUR_W-1:0];
               csr_hit       = 1'b1;
            end
            CSR_RELEASE_TIME: begin
               release_time_in = csr_wdata[DUR_W-1:0];
               csr_hit         = 1'b1;
            end
            CSR_LEFT_MASK: begin
               left_mask_in = csr_wdata;
               csr_hit      = 1'b1;
            end
            CSR_RIGHT_MASK: begin
               right_mask_in = csr_wdata;
               csr_hit       = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   // per-beat phase update
   always_comb begin
      step_state   = state_ff;
      step_toggle  = last_toggle_ff;
      result_valid = 1'b0;
      result_stop  = 1'b0;
      result_word  = clean_btn;
      if (req_paused) begin
         step_state  = ST_IDLE;
         step_toggle = '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (turbo_btn != '0) begin
                  step_state  = ST_PRESSED;
                  step_toggle = req_now_us;
               end
            end
            ST_PRESSED, ST_RELEASED: begin
               result_valid = 1'b1;
               if (state_ff == ST_PRESSED && elapsed >= GUARD_US && turbo_btn == '0) begin
                  step_state  = ST_IDLE;
                  step_toggle = '0;
                  result_stop = 1'b1;
               end else begin
                  if (elapsed >= limit) begin
                     step_state  = (state_ff == ST_PRESSED) ? ST_RELEASED : ST_PRESSED;
                     step_toggle = req_now_us;
                  end
                  if (step_state != ST_PRESSED) begin
                     result_word = clean_btn & ~turbo_mask_ff;
                  end
               end
            end
            default: begin
               step_state  = ST_IDLE;
               step_toggle = '0;
            end
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      last_toggle_in = last_toggle_ff;
      if (csr_hit) begin
         state_in       = ST_IDLE;
         last_toggle_in = '0;
      end else if (req_accept) begin
         state_in       = step_state;
         last_toggle_in = step_toggle;
      end
   end

   // response register: drop a taken beat, load a new one
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      drive_full_in  = drive_full_ff;
      drive_left_in  = drive_left_ff;
      drive_right_in = drive_right_ff;
      stopped_in     = stopped_ff;
      if (req_accept && result_valid) begin
         rsp_valid_in   = 1'b1;
         drive_full_in  = result_word;
         drive_left_in  = result_word & left_mask_ff;
         drive_right_in = result_word & right_mask_ff;
         stopped_in     = result_stop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turbo_mask_ff   <= '0;
         press_time_ff   <= PRESS_TIME_RESET;
         release_time_ff <= RELEASE_TIME_RESET;
         left_mask_ff    <= '0;
         right_mask_ff   <= '0;
         state_ff        <= ST_IDLE;
         last_toggle_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         turbo_mask_ff   <= turbo_mask_in;
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
         left_mask_ff    <= left_mask_in;
         right_mask_ff   <= right_mask_in;
         state_ff        <= state_in;
         last_toggle_ff  <= last_toggle_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drive_full_ff  <= drive_full_in;
      drive_left_ff  <= drive_left_in;
      drive_right_ff <= drive_right_in;
      stopped_ff     <= stopped_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_full  = drive_full_ff;
   assign rsp_drive_left  = drive_left_ff;
   assign rsp_drive_right = drive_right_ff;
   assign rsp_stopped     = stopped_ff;

   `TBR_ASSERT_NEXT(a_pause_idles, clock, reset, req_accept && req_paused && !csr_wr_en, state_ff == ST_IDLE)
   `TBR_ASSERT_NEXT(a_csr_idles, clock, reset, csr_hit, state_ff == ST_IDLE)
   `TBR_ASSERT_SAME(a_no_stick_bits, clock, reset, rsp_valid_ff, (drive_full_ff & STICK_PSEUDO_MASK) == '0)
   `TBR_ASSERT_SAME(a_stop_leaves_idle, clock, reset, rsp_valid_ff && stopped_ff, state_ff == ST_IDLE)

endmodule
